@@ rtl/core/rcc_pkg.sv @@
// Radix converter package: widths, register indexes, character codes,
// controller states, and the command/status structs between controller and datapath.
// No dependencies.
package rcc_pkg;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int CODE_W      = 7;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = 5;
  localparam int CFG_IDX_W   = 2;

  // Accumulator width default and digit scratch store geometry
  localparam int ACC_BITS_DEF = 32;
  localparam int STORE_DEPTH  = 32;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int COUNT_W      = STORE_AW + 1;

  // Base limits
  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 2'd1;

  // Register reset values
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_POINT  = 8'h2E;  // '.'
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UP_O   = 8'h4F;  // 'O'
  localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LO_O   = 8'h6F;  // 'o'
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 5'd10;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_STORE,
    S_READ,
    S_LOAD,
    S_SEND
  } rcc_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accum;      // fold the accepted character into the accumulator
    logic conv_init;  // start conversion, clear number state
    logic div_step;   // one restoring division bit
    logic store;      // write remainder digit, restart division
    logic load;       // load output register from store read data
  } rcc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bit_last;    // final division bit this cycle
    logic q_zero;      // quotient is zero
    logic store_full;  // this store fills the last entry
    logic out_last;    // output register holds the final digit
  } rcc_status_t;

  // Clamp a base register to its legal range
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Digit value of a character; unknown characters count as zero
  function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) t = c - CHAR_ZERO;
    else if (c >= CHAR_UP_A && c <= CHAR_UP_O) t = c - CHAR_UP_A + CHAR_W'(DIGIT_TEN);
    else if (c >= CHAR_LO_A && c <= CHAR_LO_O) t = c - CHAR_LO_A + CHAR_W'(DIGIT_TEN);
    return t[DIGIT_W-1:0];
  endfunction

  // Character code of a digit value
  function automatic logic [CODE_W-1:0] digit_code(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] t;
    if (d < DIGIT_TEN) t = CHAR_ZERO + CHAR_W'(d);
    else t = CHAR_UP_A + CHAR_W'(d - DIGIT_TEN);
    return t[CODE_W-1:0];
  endfunction

endpackage

@@ rtl/core/rcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rcc_ctrl.sv @@
// Radix converter controller: sequences accumulation, digit division,
// digit store and output emission. Depends on rcc_pkg.
module rcc_ctrl import rcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output rcc_cmd_t    cmd,
  input  rcc_status_t status
);

  rcc_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && last_char) state_next = S_INIT;
      end
      S_INIT: state_next = S_DIV;
      S_DIV: begin
        if (status.bit_last) state_next = S_STORE;
      end
      S_STORE: begin
        priority if (status.q_zero || status.store_full) state_next = S_READ;
        else state_next = S_DIV;
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = S_SEND;
      S_SEND: begin
        if (out_ready) begin
          priority if (status.out_last) state_next = S_IDLE;
          else state_next = S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.accum = in_valid;
      end
      S_INIT:  cmd.conv_init = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_STORE: cmd.store     = 1'b1;
      S_READ:  ;
      S_LOAD:  cmd.load      = 1'b1;
      S_SEND:  out_valid     = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/rcc_datapath.sv @@
// Radix converter datapath: config registers, saturating accumulator,
// bit-serial divider by the target base, digit store and output register.
// Depends on rcc_pkg and rcc_ram.
module rcc_datapath import rcc_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic [CHAR_W-1:0]    char_code,
  input  rcc_cmd_t             cmd,
  output rcc_status_t          status,
  output logic [CODE_W-1:0]    digit_char,
  output logic                 last_digit,
  output logic                 overflow
);

  localparam int PROD_W = ACC_BITS + BASE_W + 1;
  localparam int CNT_W  = $clog2(ACC_BITS);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(ACC_BITS - 1);

  logic [BASE_W-1:0]   source_base;
  logic [BASE_W-1:0]   target_base;
  logic [ACC_BITS-1:0] accumulator;
  logic                point_seen;
  logic                saturated;

  logic [ACC_BITS-1:0] quo;
  logic [DIGIT_W-1:0]  rem;
  logic [CNT_W-1:0]    bitcnt;
  logic [BASE_W-1:0]   tb;
  logic                conv_ovf;
  logic [COUNT_W-1:0]  count;

  logic [PROD_W-1:0]   prod;
  logic                acc_over;
  logic [DIGIT_W:0]    rem_shift;
  logic [DIGIT_W:0]    rem_sub;
  logic                rem_ge;
  logic [COUNT_W-1:0]  count_dec;
  logic [DIGIT_W-1:0]  rd_digit;

  // Multiply-add for the next accumulator value, with overflow detect
  always_comb begin
    prod     = PROD_W'(accumulator) * PROD_W'(clamp_base(source_base))
             + PROD_W'(char_value(char_code));
    acc_over = |prod[PROD_W-1:ACC_BITS];
  end

  // One restoring division step
  always_comb begin
    rem_shift = {rem, quo[ACC_BITS-1]};
    rem_sub   = rem_shift - {1'b0, tb};
    rem_ge    = rem_shift >= {1'b0, tb};
    count_dec = count - COUNT_W'(1);
  end

  // Config registers and per-number state
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SOURCE_BASE_RST;
      target_base <= TARGET_BASE_RST;
      accumulator <= '0;
      point_seen  <= 1'b0;
      saturated   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SOURCE_BASE: source_base <= cfg_data;
          REG_TARGET_BASE: target_base <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accum && !point_seen) begin
        if (char_code == CHAR_POINT) begin
          point_seen <= 1'b1;
        end else if (!saturated) begin
          if (acc_over) begin
            accumulator <= '1;
            saturated   <= 1'b1;
          end else begin
            accumulator <= prod[ACC_BITS-1:0];
          end
        end
      end
      // Drop the number once conversion has taken it
      if (cmd.conv_init) begin
        accumulator <= '0;
        point_seen  <= 1'b0;
        saturated   <= 1'b0;
      end
    end
  end

  // Digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.conv_init) begin
      count <= '0;
    end else if (cmd.store) begin
      count <= count + COUNT_W'(1);
    end else if (cmd.load) begin
      count <= count_dec;
    end
  end

  // Divider registers and overflow flag
  always_ff @(posedge clk) begin
    if (cmd.conv_init) begin
      quo      <= accumulator;
      rem      <= '0;
      bitcnt   <= CNT_TOP;
      tb       <= clamp_base(target_base);
      conv_ovf <= saturated;
    end else if (cmd.div_step) begin
      rem    <= rem_ge ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
      quo    <= {quo[ACC_BITS-2:0], rem_ge};
      bitcnt <= bitcnt - CNT_W'(1);
    end else if (cmd.store) begin
      rem    <= '0;
      bitcnt <= CNT_TOP;
      if (status.store_full && !status.q_zero) begin
        conv_ovf <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      digit_char <= digit_code(rd_digit);
      last_digit <= (count == COUNT_W'(1));
      overflow   <= conv_ovf;
    end
  end

  // Digit store: written least significant first, read back in reverse
  rcc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count[STORE_AW-1:0]),
    .wdata (rem),
    .raddr (count_dec[STORE_AW-1:0]),
    .rdata (rd_digit)
  );

  // Status to controller
  always_comb begin
    status.bit_last   = (bitcnt == '0);
    status.q_zero     = (quo == '0);
    status.store_full = (count == COUNT_W'(STORE_DEPTH - 1));
    status.out_last   = last_digit;
  end

endmodule

@@ rtl/core/radix_converter_core.sv @@
// Radix converter top level. Input characters take one cycle each while idle.
// The final character starts conversion (S_INIT); each digit then comes from the
// one-bit-per-cycle divider by the target base (S_DIV) and is stored (S_STORE); the
// digits are read back, loaded and sent (S_READ, S_LOAD, S_SEND), waiting on out_ready.
// One number at a time. Synchronous reset: bases return to 10 and 2, accumulator and flags clear.
module radix_converter_core import rcc_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 last_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_W-1:0]    digit_char,
  output logic                 last_digit,
  output logic                 overflow
);

  rcc_cmd_t    cmd;
  rcc_status_t status;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  rcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  rcc_datapath #(
    .ACC_BITS (ACC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_code  (char_code),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .overflow   (overflow)
  );

endmodule

@@ tb/radix_digit_checker.sv @@
// Scoreboard for the radix converter: watches the base, character and digit channels,
// predicts the digit stream of each number and counts every mismatch.
// Depends on rcc_pkg for widths, register indexes and character codes.
module radix_digit_checker import rcc_pkg::*; #(
  parameter int ACC_BITS = ACC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 last_char,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CODE_W-1:0]    digit_char,
  input  logic                 last_digit,
  input  logic                 overflow,
  output int                   fail_count,
  output int                   pending_digits,
  output int                   numbers_seen,
  output int                   digits_checked,
  output int                   saturated_numbers
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              final_digit;
    logic              sat;
  } digit_t;

  digit_t            expected_digits[$];
  digit_t            oldest;
  logic [63:0]       acc_value;
  bit                point_seen;
  bit                saturated;
  logic [BASE_W-1:0] src_reg;
  logic [BASE_W-1:0] tgt_reg;

  // Clip a base register to the usable radix range
  function automatic logic [63:0] legal_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return 64'(BASE_MIN);
    if (b > BASE_MAX) return 64'(BASE_MAX);
    return 64'(b);
  endfunction

  // Map a character to its digit value; anything unrecognized is zero
  function automatic logic [63:0] value_of_char(input logic [CHAR_W-1:0] c);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) return 64'(c - CHAR_ZERO);
    if (c inside {[CHAR_UP_A:CHAR_UP_O]}) return 64'(c - CHAR_UP_A) + 64'd10;
    if (c inside {[CHAR_LO_A:CHAR_LO_O]}) return 64'(c - CHAR_LO_A) + 64'd10;
    return 64'd0;
  endfunction

  // Map a digit value to its printed character
  function automatic logic [CODE_W-1:0] char_of_value(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] t;
    if (d < 5'd10) t = CHAR_ZERO + CHAR_W'(d);
    else t = CHAR_UP_A + CHAR_W'(d) - 8'd10;
    return t[CODE_W-1:0];
  endfunction

  // Fold one character into the value; on the final character queue its digits
  task automatic fold_char(input logic [CHAR_W-1:0] c, input logic fin);
    logic [63:0]        sb;
    logic [63:0]        d;
    logic [63:0]        v;
    logic [63:0]        tb;
    logic [DIGIT_W-1:0] rems[STORE_DEPTH];
    int                 n;
    bit                 ovf;
    digit_t             e;
    if (!point_seen) begin
      if (c == CHAR_POINT) begin
        point_seen = 1'b1;
      end else if (!saturated) begin
        sb = legal_base(src_reg);
        d = value_of_char(c);
        if (acc_value > (ACC_MAX - d) / sb) begin
          acc_value = ACC_MAX;
          saturated = 1'b1;
        end else begin
          acc_value = acc_value * sb + d;
        end
      end
    end
    if (!fin) return;

    // Peel remainders, least significant first, until the value runs out or the store is full
    tb = legal_base(tgt_reg);
    v = acc_value;
    ovf = saturated;
    n = 0;
    do begin
      if (n == STORE_DEPTH) begin
        ovf = 1'b1;
        break;
      end
      rems[n] = DIGIT_W'(v % tb);
      v = v / tb;
      n++;
    end while (v != 0);

    for (int i = n - 1; i >= 0; i--) begin
      e.code = char_of_value(rems[i]);
      e.final_digit = (i == 0);
      e.sat = ovf;
      expected_digits.push_back(e);
    end
    numbers_seen++;
    if (ovf) saturated_numbers++;
    acc_value = '0;
    point_seen = 1'b0;
    saturated = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_digits.delete();
      acc_value = '0;
      point_seen = 1'b0;
      saturated = 1'b0;
      src_reg = SOURCE_BASE_RST;
      tgt_reg = TARGET_BASE_RST;
    end else begin
      // Track base register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_BASE: src_reg = cfg_data;
          REG_TARGET_BASE: tgt_reg = cfg_data;
          default: ;
        endcase
      end
      // Predict from each accepted character request
      if (in_valid && in_ready) fold_char(char_code, last_char);
      // Compare each accepted digit against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected digit: digit_char 0x%0h with nothing pending", digit_char);
          fail_count++;
        end else begin
          oldest = expected_digits.pop_front();
          digits_checked++;
          if (digit_char !== oldest.code) begin
            $error("digit_char: expected 0x%0h, got 0x%0h", oldest.code, digit_char);
            fail_count++;
          end
          if (last_digit !== oldest.final_digit) begin
            $error("last_digit: expected %0b, got %0b", oldest.final_digit, last_digit);
            fail_count++;
          end
          if (overflow !== oldest.sat) begin
            $error("overflow: expected %0b, got %0b", oldest.sat, overflow);
            fail_count++;
          end
        end
      end
    end
    pending_digits = expected_digits.size();
  end

endmodule

@@ tb/radix_converter_core_tb.sv @@
// Top of the radix converter testbench: clock, reset, base settings and character
// stimulus with random idle bursts; radix_digit_checker does prediction and comparison.
// Depends on rcc_pkg, radix_converter_core and radix_digit_checker.
module radix_converter_core_tb import rcc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_TOTAL    = 460;
  localparam int QUIET_TAIL    = 60;
  localparam int RANDOM_PHASES = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 100;
  localparam int CYCLE_LIMIT   = 3_000_000;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [CHAR_W-1:0]    char_code;
  logic                 last_char;
  logic                 out_valid;
  logic                 out_ready;
  logic [CODE_W-1:0]    digit_char;
  logic                 last_digit;
  logic                 overflow;

  int                   fail_count;
  int                   pending_digits;
  int                   numbers_seen;
  int                   digits_checked;
  int                   saturated_numbers;
  int                   chars_sent;
  int                   cycles;
  bit                   quiet;
  logic [BASE_W-1:0]    cur_src;

  radix_converter_core DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit),
    .overflow   (overflow)
  );

  radix_digit_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .char_code         (char_code),
    .last_char         (last_char),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .digit_char        (digit_char),
    .last_digit        (last_digit),
    .overflow          (overflow),
    .fail_count        (fail_count),
    .pending_digits    (pending_digits),
    .numbers_seen      (numbers_seen),
    .digits_checked    (digits_checked),
    .saturated_numbers (saturated_numbers)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stall the digit side in random bursts, never in the quiet tail
  initial begin
    out_ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one character request, maybe after an idle burst, and hold until taken
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    quiet = (chars_sent >= CHAR_TOTAL - QUIET_TAIL);
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Drop valid and wait until every predicted digit has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_digits != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold a register write request until taken; caller drops valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
    wait_drained();
    write_reg(REG_SOURCE_BASE, src);
    write_reg(REG_TARGET_BASE, tgt);
    cfg_valid <= 1'b0;
    cur_src = src;
  endtask

  // Build one number: mostly clean digits, sometimes long, with points, noise or big digits
  task automatic send_number();
    int                len;
    int                kind;
    int                sb;
    int                d;
    int                r;
    logic [CHAR_W-1:0] c;
    kind = $urandom_range(0, 9);
    len = (kind == 0) ? $urandom_range(10, 16) : $urandom_range(1, 7);
    sb = (cur_src < BASE_MIN) ? BASE_MIN : (cur_src > BASE_MAX) ? BASE_MAX : cur_src;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      d = (kind == 3) ? $urandom_range(0, 24) : $urandom_range(0, sb - 1);
      if (kind == 1 && r < 15) c = CHAR_POINT;
      else if (kind == 2 && r < 40) c = CHAR_W'($urandom_range(0, 255));
      else if (d < 10) c = CHAR_ZERO + CHAR_W'(d);
      else c = ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + CHAR_W'(d - 10);
      send_char(c, i == len - 1);
    end
  endtask

  initial begin
    int start;
    int goal;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_code <= '0;
    last_char <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SOURCE_BASE;
    cfg_data  <= '0;
    cur_src = SOURCE_BASE_RST;
    quiet = 1'b0;
    chars_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, lowercase and oversized digit, point, unknown characters
    send_word("0");
    send_word("9a");
    send_word("1.5");
    send_word(".");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char("z", 1'b1);
    wait_drained();
    write_reg(REG_SPARE, 5'h15);
    cfg_valid <= 1'b0;
    // Saturate and emit the full-width binary value
    set_bases(BASE_MAX, BASE_MIN);
    send_word("OOOOOOO");
    set_bases(BASE_MIN, BASE_MAX);
    send_word("101");
    // Out-of-range register values clip to the legal bases
    set_bases(5'd0, 5'd31);
    send_word("11");
    set_bases(5'd26, 5'd1);
    send_word("10");

    // Random phases, each with its own base pair
    start = chars_sent;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_bases(BASE_MIN, BASE_MAX);
        1: set_bases(BASE_MAX, BASE_MIN);
        default: set_bases(BASE_W'($urandom_range(0, 31)), BASE_W'($urandom_range(0, 31)));
      endcase
      goal = start + (p + 1) * (CHAR_TOTAL - start) / RANDOM_PHASES;
      while (chars_sent < goal) send_number();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d characters in %0d numbers over %0d base settings;",
             chars_sent, numbers_seen, RANDOM_PHASES + 4);
    $display("compared %0d digits, %0d numbers saturated.", digits_checked, saturated_numbers);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
